>>> design/edcd_pkg.sv
// ----------------------------------------------------------------------------
// edcd_pkg
// shared types and constants of the ema deadband change detector
// ----------------------------------------------------------------------------
package edcd_pkg;

    localparam int NUM_CH   = 4;
    localparam int SAMPLE_W = 24;
    localparam int LIMIT_W  = 23;
    localparam int ALPHA_W  = 17;
    localparam int SECS_W   = 16;
    localparam int ADDR_W   = 5;
    localparam int APB_W    = 32;

    // unity gain in q1.16
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

    // register indexes (byte address is 4x the index)
    localparam logic [2:0] REG_ALPHA   = 3'd0;
    localparam logic [2:0] REG_SPEED   = 3'd1;
    localparam logic [2:0] REG_POWER   = 3'd2;
    localparam logic [2:0] REG_BATTERY = 3'd3;
    localparam logic [2:0] REG_HEADING = 3'd4;
    localparam logic [2:0] REG_RESYNC  = 3'd5;

    // reset values
    localparam logic [ALPHA_W-1:0] ALPHA_RST   = 17'd19661;
    localparam logic [LIMIT_W-1:0] SPEED_RST   = 23'd512;
    localparam logic [LIMIT_W-1:0] POWER_RST   = 23'd1280;
    localparam logic [LIMIT_W-1:0] BATTERY_RST = 23'd128;
    localparam logic [LIMIT_W-1:0] HEADING_RST = 23'd1280;
    localparam logic [SECS_W-1:0]  RESYNC_RST  = 16'd30;

    typedef struct packed {
        logic [ALPHA_W-1:0]             alpha;   // already clamped to one
        logic [NUM_CH-1:0][LIMIT_W-1:0] limit;
        logic [SECS_W-1:0]              resync_secs;
    } cfg_t;

    typedef struct packed {
        logic update;     // sample leaves the input register this cycle
        logic primed;     // an estimate has been loaded before
        logic force_all;  // first sample or resync: flag regardless of deviation
    } lane_ctl_t;

endpackage

>>> design/ema_deadband_change_detector.sv
// ----------------------------------------------------------------------------
// ema_deadband_change_detector
// send-on-delta change detector with a per-channel exponential-average predictor
// ----------------------------------------------------------------------------
// Each input beat is either a four-channel sample (s_tuser = 0) or a one-second
// tick (s_tuser = 1). A sample yields one result beat whose m_tdata bits say
// which channels moved further than their limit from the running estimate;
// m_tuser marks a forced resync, in which every channel is flagged. The first
// sample after reset flags every channel and loads the estimates directly.
// Ticks advance a saturating seconds counter and yield no result. Timing: one
// beat per clock in each direction while the result side does not stall; a
// sample is taken into the input register and its result beat is offered from
// the result register. All the work of an item (subtract, 25x18 multiply, add,
// compare, four lanes in parallel) sits between those two registers, so the
// estimates are up to date for the very next item. Registers are to be written
// over the apb port only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ema_deadband_change_detector (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input channel
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [95:0]                 s_tdata,  // speed, power, battery, heading
    input  logic [0:0]                  s_tuser,  // func: 0 sample, 1 tick
    // result channel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,  // send_speed, send_power,
                                                  // send_battery, send_heading, pad
    output logic [0:0]                  m_tuser,  // resync_flag
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [edcd_pkg::ADDR_W-1:0] paddr,
    input  logic [edcd_pkg::APB_W-1:0]  pwdata,
    output logic [edcd_pkg::APB_W-1:0]  prdata,
    output logic                        pready
);
    import edcd_pkg::*;

    cfg_t cfg;

    // input register
    logic                           in_vld_reg;
    logic                           in_tick_reg;
    logic [NUM_CH-1:0][SAMPLE_W-1:0] in_data_reg;

    // result register
    logic              out_vld_reg;
    logic [NUM_CH-1:0] out_send_reg;
    logic              out_resync_reg;

    // detector state
    logic              primed_reg;
    logic [SECS_W-1:0] secs_reg;
    logic [SECS_W-1:0] secs_next;

    logic              advance;
    logic              take_sample;
    logic              resync_due;
    logic [NUM_CH-1:0] send;
    lane_ctl_t         ctl;

    edcd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ticks never need the result register, samples need it free or draining
    assign advance     = in_vld_reg & (in_tick_reg | ~out_vld_reg | m_tready);
    assign take_sample = advance & ~in_tick_reg;
    assign s_tready    = ~in_vld_reg | advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid & s_tready) begin
            in_tick_reg <= s_tuser[0];
            in_data_reg <= s_tdata;
        end
    end

    // resync once the counter has reached the interval
    assign resync_due = secs_reg >= cfg.resync_secs;

    always_comb begin
        secs_next = secs_reg;
        if (advance) begin
            if (in_tick_reg) begin
                if (secs_reg != '1) begin
                    secs_next = secs_reg + 1'b1;
                end
            end else if (resync_due) begin
                secs_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            secs_reg   <= '0;
            primed_reg <= 1'b0;
        end else begin
            secs_reg <= secs_next;
            if (take_sample) begin
                primed_reg <= 1'b1;
            end
        end
    end

    assign ctl.update    = take_sample;
    assign ctl.primed    = primed_reg;
    assign ctl.force_all = resync_due | ~primed_reg;

    for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
        edcd_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .sample  ($signed(in_data_reg[i])),
            .limit   (cfg.limit[i]),
            .alpha   (cfg.alpha),
            .send    (send[i])
        );
    end

    // result register, refilled in the same cycle it drains
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (take_sample) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_sample) begin
            out_send_reg   <= send;
            out_resync_reg <= resync_due;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(8-NUM_CH){1'b0}}, out_send_reg};
    assign m_tuser  = out_resync_reg;

endmodule

>>> design/edcd_regs.sv
// ----------------------------------------------------------------------------
// edcd_regs
// apb register file for smoothing factor, channel limits and resync interval
// ----------------------------------------------------------------------------
module edcd_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [edcd_pkg::ADDR_W-1:0]  paddr,
    input  logic [edcd_pkg::APB_W-1:0]   pwdata,
    output logic [edcd_pkg::APB_W-1:0]   prdata,
    output logic                         pready,
    output edcd_pkg::cfg_t               cfg
);
    import edcd_pkg::*;

    logic [ALPHA_W-1:0]             alpha_reg;
    logic [NUM_CH-1:0][LIMIT_W-1:0] limit_reg;
    logic [SECS_W-1:0]              resync_reg;
    logic                           wr_en;
    logic [2:0]                     idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg    <= ALPHA_RST;
            limit_reg[0] <= SPEED_RST;
            limit_reg[1] <= POWER_RST;
            limit_reg[2] <= BATTERY_RST;
            limit_reg[3] <= HEADING_RST;
            resync_reg   <= RESYNC_RST;
        end else if (wr_en) begin
            case (idx)
                REG_ALPHA:   alpha_reg    <= pwdata[ALPHA_W-1:0];
                REG_SPEED:   limit_reg[0] <= pwdata[LIMIT_W-1:0];
                REG_POWER:   limit_reg[1] <= pwdata[LIMIT_W-1:0];
                REG_BATTERY: limit_reg[2] <= pwdata[LIMIT_W-1:0];
                REG_HEADING: limit_reg[3] <= pwdata[LIMIT_W-1:0];
                REG_RESYNC:  resync_reg   <= pwdata[SECS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ALPHA:   prdata = {{(APB_W-ALPHA_W){1'b0}}, alpha_reg};
            REG_SPEED:   prdata = {{(APB_W-LIMIT_W){1'b0}}, limit_reg[0]};
            REG_POWER:   prdata = {{(APB_W-LIMIT_W){1'b0}}, limit_reg[1]};
            REG_BATTERY: prdata = {{(APB_W-LIMIT_W){1'b0}}, limit_reg[2]};
            REG_HEADING: prdata = {{(APB_W-LIMIT_W){1'b0}}, limit_reg[3]};
            REG_RESYNC:  prdata = {{(APB_W-SECS_W){1'b0}}, resync_reg};
            default:     prdata = '0;
        endcase
    end

    // gains above one behave as one
    assign cfg.alpha       = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign cfg.limit       = limit_reg;
    assign cfg.resync_secs = resync_reg;

endmodule

>>> design/edcd_lane.sv
// ----------------------------------------------------------------------------
// edcd_lane
// one channel: deviation test against the limit and ema estimate update
// ----------------------------------------------------------------------------
module edcd_lane (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  edcd_pkg::lane_ctl_t                 ctl,
    input  logic signed [edcd_pkg::SAMPLE_W-1:0] sample,
    input  logic [edcd_pkg::LIMIT_W-1:0]        limit,
    input  logic [edcd_pkg::ALPHA_W-1:0]        alpha,
    output logic                                send
);
    import edcd_pkg::*;

    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + ALPHA_W + 1;

    logic signed [SAMPLE_W-1:0] est_reg;
    logic signed [SAMPLE_W-1:0] est_next;
    logic signed [DIFF_W-1:0]   diff;
    logic [DIFF_W-1:0]          abs_diff;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   step;
    logic signed [DIFF_W-1:0]   sum;

    assign diff     = DIFF_W'(sample) - DIFF_W'(est_reg);
    assign abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign send     = ctl.force_all | (abs_diff > DIFF_W'(limit));

    // floor(alpha * diff / 2^16), stays between zero and diff
    assign prod = PROD_W'(diff) * $signed({1'b0, alpha});
    assign step = prod >>> 16;
    assign sum  = DIFF_W'(est_reg) + step[DIFF_W-1:0];

    assign est_next = ctl.primed ? sum[SAMPLE_W-1:0] : sample;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_reg <= '0;
        end else if (ctl.update) begin
            est_reg <= est_next;
        end
    end

endmodule

>>> design/edcd_checker.sv
// ----------------------------------------------------------------------------
// edcd_checker
// port-level checks on the change detector, bound to the top level
// ----------------------------------------------------------------------------
module edcd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [0:0]  m_tuser
);

    // result side empties on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a resync flags every channel
    a_resync_all: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[3:0] == 4'hf)
        else $error("resync without all channels flagged");

    // input only stalls behind a stalled result
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while result side free");

endmodule

bind ema_deadband_change_detector edcd_checker u_edcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> bench/ema_deadband_change_detector_tb.sv
// ----------------------------------------------------------------------------
// ema_deadband_change_detector_tb
// self-checking bench for the send-on-delta change detector
// ----------------------------------------------------------------------------
// Sample and tick beats go into the input channel and the flag beats that come
// back are checked against a behavioural tracker of the estimates, the primed
// bit and the seconds counter. A short table of directed beats comes first,
// then random phases under changing register settings. Both sides of the
// stream idle at random but in two phases that run flat out, and registers
// are only rewritten once the block has drained.
// ----------------------------------------------------------------------------
module ema_deadband_change_detector_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import edcd_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int PIPE_CYCLES     = 4;

    // item kinds carried on tuser
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // index past the end of the register map, writes there must be dropped
    localparam logic [2:0] REG_SPARE = 3'd6;

    localparam logic [LIMIT_W-1:0] LIMIT_MAX  = '1;
    localparam logic [SECS_W-1:0]  SECS_MAX   = '1;
    localparam logic [ALPHA_W-1:0] ALPHA_FULL = '1;

    typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] quad_t;

    typedef struct packed {
        logic              resync;
        logic [NUM_CH-1:0] send;
    } flag_set_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  reg_idx;
        logic [31:0] reg_val;
        logic        func;
        quad_t       smp;
        bit          typed;   // expectation written into the table
        flag_set_t   fl;
    } stim_row_t;

    // ------------------------------------------------------------------------
    // clock, reset and dut
    // ------------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #5 aclk = ~aclk;

    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [95:0]       s_tdata  = '0;  // speed, power, battery, heading
    logic [0:0]        s_tuser  = '0;  // func
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;        // send_speed, send_power, send_battery,
                                       // send_heading, zero pad
    logic [0:0]        m_tuser;        // resync_flag
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [APB_W-1:0]  pwdata   = '0;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    ema_deadband_change_detector i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------------
    // tracked state of the block
    // ------------------------------------------------------------------------
    logic [ALPHA_W-1:0]             cfg_alpha  = ALPHA_RST;
    logic [NUM_CH-1:0][LIMIT_W-1:0] cfg_limit  = {HEADING_RST, BATTERY_RST,
                                                  POWER_RST, SPEED_RST};
    logic [SECS_W-1:0]              cfg_resync = RESYNC_RST;

    quad_t             est_vec    = '0;
    bit                primed     = 1'b0;
    logic [SECS_W-1:0] secs_count = '0;

    flag_set_t flags_due[$];    // flag beats still to come, oldest first
    stim_row_t directed_rows[$];

    int  mismatches  = 0;
    int  cycle_count = 0;
    bit  no_idle     = 1'b0;    // both sides run flat out while set

    string chan_name[NUM_CH] = '{"speed", "power", "battery", "heading"};

    // ------------------------------------------------------------------------
    // flag and estimate tracker
    // ------------------------------------------------------------------------
    task automatic track_item(input logic func, input quad_t smp,
                              output bit gives, output flag_set_t fl);
        longint xv, ev, dv, adv;
        logic [ALPHA_W-1:0] a;
        bit force_all;
        gives = 1'b0;
        fl    = '0;
        if (func == FUNC_TICK) begin
            // seconds counter sticks at its top value
            if (secs_count != SECS_MAX)
                secs_count = secs_count + 1'b1;
        end else begin
            gives     = 1'b1;
            fl.resync = (secs_count >= cfg_resync);
            force_all = fl.resync || !primed;
            if (fl.resync)
                secs_count = '0;
            a = (cfg_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg_alpha;
            for (int c = 0; c < NUM_CH; c++) begin
                xv = longint'($signed(smp[c]));
                ev = longint'($signed(est_vec[c]));
                dv = xv - ev;
                adv = (dv < 0) ? -dv : dv;
                fl.send[c] = force_all || (adv > longint'(cfg_limit[c]));
                // first sample loads, later ones move by a floored fraction
                if (!primed)
                    ev = xv;
                else
                    ev = ev + ((dv * longint'(a)) >>> 16);
                est_vec[c] = ev[SAMPLE_W-1:0];
            end
            primed = 1'b1;
        end
    endtask

    // random sample, often near the deadband edges of the current estimates
    function automatic quad_t draw_sample();
        quad_t  smp;
        longint v, off;
        logic [31:0] raw;
        for (int c = 0; c < NUM_CH; c++) begin
            v = longint'($signed(est_vec[c]));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    // limit - 1, limit or limit + 1 away, either side
                    off = longint'(cfg_limit[c]) + longint'($urandom_range(0, 2)) - 1;
                    v = $urandom_range(0, 1) ? v + off : v - off;
                end
                4, 5, 6: v = v + longint'($urandom_range(0, 6000)) - 3000;
                default: begin
                    raw = $urandom;
                    v = longint'($signed(raw[SAMPLE_W-1:0]));
                end
            endcase
            if (v > 64'sd8388607)
                v = 64'sd8388607;
            if (v < -64'sd8388608)
                v = -64'sd8388608;
            smp[c] = v[SAMPLE_W-1:0];
        end
        return smp;
    endfunction

    // ------------------------------------------------------------------------
    // drivers, all called at a falling edge and returning at one
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        case (idx)
            REG_ALPHA:   cfg_alpha    = val[ALPHA_W-1:0];
            REG_SPEED:   cfg_limit[0] = val[LIMIT_W-1:0];
            REG_POWER:   cfg_limit[1] = val[LIMIT_W-1:0];
            REG_BATTERY: cfg_limit[2] = val[LIMIT_W-1:0];
            REG_HEADING: cfg_limit[3] = val[LIMIT_W-1:0];
            REG_RESYNC:  cfg_resync   = val[SECS_W-1:0];
            default: ;   // outside the map, nothing changes
        endcase
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_beat(input logic func, input quad_t smp,
                             input bit typed, input flag_set_t typed_fl);
        int        gap;
        bit        gives;
        flag_set_t fl;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = func;
        s_tdata  = smp;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        // beat taken at this edge
        track_item(func, smp, gives, fl);
        if (gives)
            flags_due.push_back(typed ? typed_fl : fl);
        @(negedge aclk);
    endtask

    // stop sending and let every outstanding beat, and any tick behind it, clear
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (flags_due.size() != 0)
            @(posedge aclk);
        repeat (PIPE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic add_item(input logic func, input int sp, input int pw,
                            input int bt, input int hd, input bit typed,
                            input logic [NUM_CH-1:0] snd, input logic rs);
        stim_row_t row;
        row.kind      = ROW_ITEM;
        row.reg_idx   = REG_ALPHA;
        row.reg_val   = '0;
        row.func      = func;
        row.smp       = {hd[SAMPLE_W-1:0], bt[SAMPLE_W-1:0],
                         pw[SAMPLE_W-1:0], sp[SAMPLE_W-1:0]};
        row.typed     = typed;
        row.fl.send   = snd;
        row.fl.resync = rs;
        directed_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [2:0] idx, input logic [31:0] val);
        stim_row_t row;
        row.kind    = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = val;
        row.func    = FUNC_SAMPLE;
        row.smp     = '0;
        row.typed   = 1'b0;
        row.fl      = '0;
        directed_rows.push_back(row);
    endtask

    // all six registers for one random phase
    task automatic set_phase(input int p);
        logic [31:0] al, rs;
        logic [NUM_CH-1:0][LIMIT_W-1:0] lim;
        case (p)
            0: begin
                al  = 32'(ALPHA_RST);
                lim = {HEADING_RST, BATTERY_RST, POWER_RST, SPEED_RST};
                rs  = 32'(RESYNC_RST);
            end
            1: begin
                // alpha and limits at the bottom: frozen estimates, zero deadband
                al  = '0;
                lim = '0;
                rs  = 32'd1;
            end
            2: begin
                // alpha and limits at the top, every sample a resync
                al  = 32'(ALPHA_FULL);
                lim = {NUM_CH{LIMIT_MAX}};
                rs  = '0;
            end
            3: begin
                al = 32'(ALPHA_ONE);
                for (int c = 0; c < NUM_CH; c++)
                    lim[c] = LIMIT_W'($urandom_range(0, 2048));
                rs = $urandom_range(2, 6);
            end
            default: begin
                al = ($urandom_range(0, 7) == 0) ? $urandom_range(65537, 131071)
                                                 : $urandom_range(0, 65536);
                for (int c = 0; c < NUM_CH; c++)
                    lim[c] = ($urandom_range(0, 3) == 0)
                             ? LIMIT_W'($urandom_range(0, 8388607))
                             : LIMIT_W'($urandom_range(0, 4096));
                rs = $urandom_range(1, 12);
            end
        endcase
        write_reg(REG_ALPHA, al);
        write_reg(REG_SPEED, 32'(lim[0]));
        write_reg(REG_POWER, 32'(lim[1]));
        write_reg(REG_BATTERY, 32'(lim[2]));
        write_reg(REG_HEADING, 32'(lim[3]));
        write_reg(REG_RESYNC, rs);
    endtask

    // ------------------------------------------------------------------------
    // result side: random back-pressure
    // ------------------------------------------------------------------------
    initial begin : result_pacer
        int stall;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid)
                @(posedge aclk);
            @(negedge aclk);
        end
    end

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        // keep the log short once things have clearly gone wrong
        if (mismatches <= 40)
            $display("mismatch on %s at cycle %0d: got %0h, want %0h",
                     what, cycle_count, got, want);
    endtask

    always @(posedge aclk) begin : result_check
        flag_set_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (flags_due.size() == 0) begin
                report_mismatch("beat with nothing due", 32'(m_tdata), 0);
            end else begin
                want = flags_due.pop_front();
                for (int c = 0; c < NUM_CH; c++)
                    if (m_tdata[c] !== want.send[c])
                        report_mismatch({"send_", chan_name[c]}, 32'(m_tdata[c]),
                                        32'(want.send[c]));
                if (m_tuser[0] !== want.resync)
                    report_mismatch("resync_flag", 32'(m_tuser), 32'(want.resync));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        bit    first_resync;
        quad_t noise;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // only one reset, so the seed picks which flavour of first sample is seen:
        // plain first sample, or one that finds a resync already due
        first_resync = 1'($urandom_range(0, 1));
        if (first_resync)
            write_reg(REG_RESYNC, '0);

        // first sample after reset flags everything and loads the estimates
        add_item(FUNC_SAMPLE, 8388607, -8388608, 0, -1, 1'b1, 4'b1111, first_resync);
        add_cfg(REG_RESYNC, 32'(RESYNC_RST));
        // same sample again: no deviation anywhere
        add_item(FUNC_SAMPLE, 8388607, -8388608, 0, -1, 1'b1, 4'b0000, 1'b0);
        // full-scale swing on every channel
        add_item(FUNC_SAMPLE, -8388608, 8388607, 8388607, -8388608, 1'b1, 4'b1111,
                 1'b0);
        add_item(FUNC_SAMPLE, 0, 0, 0, 0, 1'b0, '0, 1'b0);
        // one tick reaches a one-second interval, next sample is a resync
        add_cfg(REG_RESYNC, 1);
        add_item(FUNC_TICK, 32'h00A5A5A5, -1, 32'h005A5A5A, 0, 1'b0, '0, 1'b0);
        add_item(FUNC_SAMPLE, 0, 0, 0, 0, 1'b1, 4'b1111, 1'b1);
        add_item(FUNC_SAMPLE, 256, -256, 128, -128, 1'b0, '0, 1'b0);
        // zero interval: every sample resyncs
        add_cfg(REG_RESYNC, 0);
        add_item(FUNC_SAMPLE, 256, -256, 128, -128, 1'b1, 4'b1111, 1'b1);
        // unity alpha: estimate jumps onto the sample
        add_cfg(REG_ALPHA, 32'(ALPHA_ONE));
        add_cfg(REG_RESYNC, 32'(SECS_MAX));
        add_item(FUNC_SAMPLE, 100, 200, 300, 400, 1'b0, '0, 1'b0);
        add_item(FUNC_SAMPLE, 100, 200, 300, 400, 1'b1, 4'b0000, 1'b0);
        // alpha beyond one is clamped, so again no overshoot
        add_cfg(REG_ALPHA, 32'(ALPHA_FULL));
        add_item(FUNC_SAMPLE, -5000, 7, -8388608, 8388607, 1'b0, '0, 1'b0);
        add_item(FUNC_SAMPLE, -5000, 7, -8388608, 8388607, 1'b1, 4'b0000, 1'b0);
        // zero alpha freezes the estimates; limits at both ends
        add_cfg(REG_ALPHA, 0);
        add_cfg(REG_SPEED, 0);
        add_cfg(REG_POWER, 32'(LIMIT_MAX));
        add_cfg(REG_BATTERY, 0);
        add_cfg(REG_HEADING, 32'hFFFF_FFFF);
        add_item(FUNC_SAMPLE, -4999, 6, -8388607, 8388607, 1'b0, '0, 1'b0);
        add_item(FUNC_SAMPLE, -4999, 6, -8388607, 8388607, 1'b0, '0, 1'b0);
        // write outside the register map is dropped
        add_cfg(REG_SPARE, 32'h0000_0001);
        add_item(FUNC_TICK, 0, 0, 0, 0, 1'b0, '0, 1'b0);
        add_item(FUNC_SAMPLE, 12345, -12345, 1, -1, 1'b0, '0, 1'b0);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                wait_drained();
                write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
            end else begin
                send_beat(directed_rows[r].func, directed_rows[r].smp,
                          directed_rows[r].typed, directed_rows[r].fl);
            end
        end

        // random phases, each under its own register setting
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            no_idle = (p == 1) || (p == 4);
            set_phase(p);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 99) < 22) begin
                    noise = {$urandom, $urandom, $urandom};
                    send_beat(FUNC_TICK, noise, 1'b0, '0);
                end else begin
                    send_beat(FUNC_SAMPLE, draw_sample(), 1'b0, '0);
                end
                // hold the input off mid-phase until the output has caught up
                if (p == 2 && n == 60)
                    wait_drained();
            end
        end
        no_idle = 1'b0;

        // let the last beats out, then a little slack for anything stray
        s_tvalid = 1'b0;
        while (flags_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> ema_deadband_change_detector.f
design/edcd_pkg.sv
design/edcd_regs.sv
design/edcd_lane.sv
design/ema_deadband_change_detector.sv
design/edcd_checker.sv
bench/ema_deadband_change_detector_tb.sv
